@@ rtl/pfa_pkg.sv @@
// ----------------------------------------------------------------------------
// pfa_pkg
// Shared types, codes and helper functions for the ARGB pixel converter.
// ----------------------------------------------------------------------------
package pfa_pkg;

    // Sizes
    localparam int MAX_DIM_DEFAULT  = 8192;
    localparam int PALETTE_ENTRIES  = 256;
    localparam int PAL_IDX_W        = $clog2(PALETTE_ENTRIES);
    localparam int ARGB_W           = 32;
    localparam int COORD_W          = 13;
    localparam int CFG_DATA_W       = 14;
    localparam int CFG_IDX_W        = 3;

    // Pixel coding constants
    localparam logic [ARGB_W-1:0] ALPHA_FULL  = 32'hFF00_0000;
    localparam logic [ARGB_W-1:0] RGB24_MASK  = 32'h00FF_FFFF;
    localparam int                RED565_SHIFT = 11;
    localparam int                GRN565_SHIFT = 5;

    // Register reset values
    localparam logic [CFG_DATA_W-1:0] SRC_WIDTH_RESET  = 14'd640;
    localparam logic [CFG_DATA_W-1:0] SRC_HEIGHT_RESET = 14'd480;
    localparam logic [CFG_DATA_W-1:0] DST_WIDTH_RESET  = 14'd640;
    localparam logic [CFG_DATA_W-1:0] DST_HEIGHT_RESET = 14'd480;

    // Input word function codes
    localparam logic FUNC_PALETTE_WRITE = 1'b0;
    localparam logic FUNC_PIXEL         = 1'b1;

    typedef enum logic [1:0] {
        FMT_PALETTE  = 2'd0,
        FMT_RGB565   = 2'd1,
        FMT_BGR24    = 2'd2,
        FMT_DIRECT32 = 2'd3
    } src_fmt_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SOURCE_FORMAT = 3'd0,
        REG_SRC_WIDTH     = 3'd1,
        REG_SRC_HEIGHT    = 3'd2,
        REG_DST_WIDTH     = 3'd3,
        REG_DST_HEIGHT    = 3'd4
    } cfg_reg_t;

    typedef struct packed {
        logic                 func;
        logic [PAL_IDX_W-1:0] palette_index;
        logic [ARGB_W-1:0]    palette_value;
        logic [ARGB_W-1:0]    pixel_value;
    } in_word_t;

    typedef struct packed {
        logic [ARGB_W-1:0]  argb;
        logic [COORD_W-1:0] dest_x;
        logic [COORD_W-1:0] dest_y;
        logic               last_pixel;
    } out_word_t;

    // Palette port controls
    typedef struct packed {
        logic                 rd_en;
        logic [PAL_IDX_W-1:0] rd_idx;
        logic                 wr_en;
        logic [PAL_IDX_W-1:0] wr_idx;
        logic [ARGB_W-1:0]    wr_data;
    } pal_req_t;

    // Grayscale ramp entry with full alpha (palette reset contents)
    function automatic logic [ARGB_W-1:0] gray_entry(input logic [PAL_IDX_W-1:0] idx);
        return ALPHA_FULL | {8'h00, idx, idx, idx};
    endfunction

    // Conversion for the formats that need no palette lookup
    function automatic logic [ARGB_W-1:0] convert_direct(input src_fmt_t fmt,
                                                         input logic [ARGB_W-1:0] pv);
        logic [7:0] r8;
        logic [7:0] g8;
        logic [7:0] b8;
        r8 = {pv[RED565_SHIFT +: 5], 3'b000};
        g8 = {pv[GRN565_SHIFT +: 6], 2'b00};
        b8 = {pv[4:0], 3'b000};
        case (fmt)
            FMT_RGB565: return ALPHA_FULL | {8'h00, r8, g8, b8};
            FMT_BGR24:  return (pv & RGB24_MASK) | ALPHA_FULL;
            default:    return pv;
        endcase
    endfunction

endpackage

@@ rtl/pfa_palette.sv @@
// ----------------------------------------------------------------------------
// pfa_palette
// 256 x 32 palette RAM, one access per cycle, registered read data. Per-entry
// valid bits stand in for the grayscale reset contents.
// ----------------------------------------------------------------------------
module pfa_palette (
    input  logic                     clk,
    input  logic                     rst_n,
    input  pfa_pkg::pal_req_t        req,
    output logic [pfa_pkg::ARGB_W-1:0] rd_data
);
    import pfa_pkg::*;

    logic [ARGB_W-1:0]          mem [PALETTE_ENTRIES];
    logic [PALETTE_ENTRIES-1:0] entry_valid_reg;
    logic [ARGB_W-1:0]          rd_data_reg;
    logic [PAL_IDX_W-1:0]       rd_idx_reg;
    logic                       rd_valid_reg;

    // RAM array: write port and registered read port
    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_idx] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            rd_data_reg <= mem[req.rd_idx];
            rd_idx_reg  <= req.rd_idx;
        end
    end

    // Written-entry flags; cleared entries read back as the gray ramp
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_valid_reg <= '0;
            rd_valid_reg    <= 1'b0;
        end
        else
        begin
            if (req.wr_en)
            begin
                entry_valid_reg[req.wr_idx] <= 1'b1;
            end
            if (req.rd_en)
            begin
                rd_valid_reg <= entry_valid_reg[req.rd_idx];
            end
        end
    end

    assign rd_data = rd_valid_reg ? rd_data_reg : gray_entry(rd_idx_reg);

`ifndef SYNTHESIS
    // read and write come from different words, never the same cycle
    a_one_access: assert property (@(posedge clk) disable iff (!rst_n)
        !(req.rd_en && req.wr_en))
        else $error("palette read and write in the same cycle");

    // a written entry is marked valid from then on
    a_wr_marks_valid: assert property (@(posedge clk) disable iff (!rst_n)
        req.wr_en |=> entry_valid_reg[$past(req.wr_idx)])
        else $error("palette write did not mark entry valid");
`endif

endmodule

@@ rtl/pixel_format_to_argb_converter.sv @@
// ----------------------------------------------------------------------------
// pixel_format_to_argb_converter
// Converts a raster stream of palette, RGB565, BGR24 or 32-bit pixels to ARGB.
// ----------------------------------------------------------------------------
// The block takes one input word per clock while in_ready is high and returns
// at most one ARGB word per input. The edge that accepts a pixel word reads
// the 256-entry palette RAM (one read or one write a cycle) into stage 1; the
// output register is loaded from stage 1 when that register is free or
// draining. Palette writes and pixels outside the copied region (the smaller
// of source and destination size) give no output but still take an input word.
// With out_ready held high the throughput is one word per clock; a stalled
// output holds up to two words inside before in_ready drops. The palette
// comes out of reset holding a full-alpha grayscale ramp, with no clearing
// pass. Sizes of 0 are used as 1 and sizes above MAX_DIM as MAX_DIM. Write
// configuration only while no words are in flight.
// ----------------------------------------------------------------------------
module pixel_format_to_argb_converter #(
    parameter int MAX_DIM = pfa_pkg::MAX_DIM_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  pfa_pkg::in_word_t               in_word,
    output logic                            out_valid,
    input  logic                            out_ready,
    output pfa_pkg::out_word_t              out_word,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [pfa_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [pfa_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import pfa_pkg::*;

    localparam int DIM_W = $clog2(MAX_DIM + 1);
    localparam int CNT_W = $clog2(MAX_DIM);

    // Size clamp applied when a dimension register is written
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_DATA_W-1:0] v);
        logic [31:0] v32;
        v32 = 32'(v);
        if (v32 == 32'd0)
            return DIM_W'(1);
        else if (v32 > 32'(MAX_DIM))
            return DIM_W'(MAX_DIM);
        else
            return DIM_W'(v32);
    endfunction

    src_fmt_t          fmt_reg;
    logic [DIM_W-1:0]  src_w_reg;
    logic [DIM_W-1:0]  src_h_reg;
    logic [DIM_W-1:0]  dst_w_reg;
    logic [DIM_W-1:0]  dst_h_reg;

    logic [CNT_W-1:0]  col_reg;
    logic [CNT_W-1:0]  col_next;
    logic [CNT_W-1:0]  row_reg;
    logic [CNT_W-1:0]  row_next;

    logic              s1_valid_reg;
    logic              s1_valid_next;
    logic [ARGB_W-1:0] s1_conv_reg;
    logic              s1_use_pal_reg;
    logic [COORD_W-1:0] s1_x_reg;
    logic [COORD_W-1:0] s1_y_reg;
    logic              s1_last_reg;

    logic              out_valid_reg;
    logic              out_valid_next;
    out_word_t         out_word_reg;

    logic [DIM_W-1:0]  copy_w;
    logic [DIM_W-1:0]  copy_h;
    logic [DIM_W-1:0]  col_ext;
    logic [DIM_W-1:0]  row_ext;
    logic              in_accept;
    logic              pixel_accept;
    logic              emit;
    logic              is_last;
    logic              load_s1;
    logic              s1_move;
    pal_req_t          pal_req;
    logic [ARGB_W-1:0] pal_rd_data;

    // Configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fmt_reg   <= FMT_PALETTE;
            src_w_reg <= clamp_dim(SRC_WIDTH_RESET);
            src_h_reg <= clamp_dim(SRC_HEIGHT_RESET);
            dst_w_reg <= clamp_dim(DST_WIDTH_RESET);
            dst_h_reg <= clamp_dim(DST_HEIGHT_RESET);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_SOURCE_FORMAT: fmt_reg   <= src_fmt_t'(cfg_data[1:0]);
                REG_SRC_WIDTH:     src_w_reg <= clamp_dim(cfg_data);
                REG_SRC_HEIGHT:    src_h_reg <= clamp_dim(cfg_data);
                REG_DST_WIDTH:     dst_w_reg <= clamp_dim(cfg_data);
                REG_DST_HEIGHT:    dst_h_reg <= clamp_dim(cfg_data);
                default:           ;
            endcase
        end
    end

    // Copied region and position checks
    assign copy_w  = (src_w_reg < dst_w_reg) ? src_w_reg : dst_w_reg;
    assign copy_h  = (src_h_reg < dst_h_reg) ? src_h_reg : dst_h_reg;
    assign col_ext = DIM_W'(col_reg);
    assign row_ext = DIM_W'(row_reg);
    assign emit    = (col_ext < copy_w) && (row_ext < copy_h);
    assign is_last = (col_ext == copy_w - DIM_W'(1)) && (row_ext == copy_h - DIM_W'(1));

    // Handshake: stage 1 moves when the output register is free or draining
    assign s1_move      = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready     = !s1_valid_reg || !out_valid_reg || out_ready;
    assign in_accept    = in_valid && in_ready;
    assign pixel_accept = in_accept && (in_word.func == FUNC_PIXEL);
    assign load_s1      = pixel_accept && emit;

    // Raster counters
    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (pixel_accept)
        begin
            if (col_ext >= src_w_reg - DIM_W'(1))
            begin
                col_next = '0;
                if (row_ext >= src_h_reg - DIM_W'(1))
                    row_next = '0;
                else
                    row_next = row_reg + CNT_W'(1);
            end
            else
            begin
                col_next = col_reg + CNT_W'(1);
            end
        end
    end

    // Palette access
    always_comb
    begin
        pal_req.rd_en   = load_s1 && (fmt_reg == FMT_PALETTE);
        pal_req.rd_idx  = in_word.pixel_value[PAL_IDX_W-1:0];
        pal_req.wr_en   = in_accept && (in_word.func == FUNC_PALETTE_WRITE);
        pal_req.wr_idx  = in_word.palette_index;
        pal_req.wr_data = in_word.palette_value;
    end

    pfa_palette u_palette (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (pal_req),
        .rd_data (pal_rd_data)
    );

    // Pipeline valid flags
    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (load_s1)
            s1_valid_next = 1'b1;
        else if (s1_move)
            s1_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (s1_move)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg       <= '0;
            row_reg       <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            col_reg       <= col_next;
            row_reg       <= row_next;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Stage 1 payload: direct conversion and coordinates
    always_ff @(posedge clk)
    begin
        if (load_s1)
        begin
            s1_conv_reg    <= convert_direct(fmt_reg, in_word.pixel_value);
            s1_use_pal_reg <= (fmt_reg == FMT_PALETTE);
            s1_x_reg       <= COORD_W'(col_reg);
            s1_y_reg       <= COORD_W'(row_reg);
            s1_last_reg    <= is_last;
        end
    end

    // Output register: pick palette word or direct conversion
    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            out_word_reg.argb       <= s1_use_pal_reg ? pal_rd_data : s1_conv_reg;
            out_word_reg.dest_x     <= s1_x_reg;
            out_word_reg.dest_y     <= s1_y_reg;
            out_word_reg.last_pixel <= s1_last_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

`ifndef SYNTHESIS
    // palette writes never move the raster position
    a_wr_holds_counters: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && in_word.func == FUNC_PALETTE_WRITE) |=>
            ($stable(col_reg) && $stable(row_reg)))
        else $error("palette write moved the raster counters");

    // both stages full and output stalled: no new word may enter
    a_full_stalls_input: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && out_valid_reg && !out_ready) |-> !in_ready)
        else $error("input accepted with pipeline full");

    // last flag sits on the corner of the copied region
    a_last_corner: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_word_reg.last_pixel) |->
            ((out_word_reg.dest_x == COORD_W'(copy_w - DIM_W'(1))) &&
             (out_word_reg.dest_y == COORD_W'(copy_h - DIM_W'(1)))))
        else $error("last_pixel away from region corner");

    // an emitted pixel always reaches stage 1 next cycle
    a_load_fills_s1: assert property (@(posedge clk) disable iff (!rst_n)
        load_s1 |=> s1_valid_reg)
        else $error("emitted pixel lost before stage 1");
`endif

endmodule
